/* rtl/bpdb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpdb_pkg;

	// Table geometry
	localparam int NUM_BANDS        = 32;
	localparam int NUM_CHANNELS     = 2;
	localparam int SAMPLES_PER_BAND = 9;
	localparam int LEVEL_COUNT      = NUM_BANDS * NUM_CHANNELS;
	localparam int IDX_W            = $clog2(LEVEL_COUNT);

	// Field widths
	localparam int BAND_W   = 5;
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;
	localparam int FACTOR_W = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Opcodes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_DECAY  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 2'd2;

	localparam logic [CFG_W-1:0]    LEVEL_OFFSET_RST   = 16'd25600;
	localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST   = 8'd251;
	localparam logic [CFG_W-1:0]    SNAP_THRESHOLD_RST = 16'd26;

	// Sum of squares: each square is at most 2^30
	localparam int SQ_W    = 31;
	localparam int SUM_W   = SQ_W + $clog2(SAMPLES_PER_BAND);
	localparam int E_W     = $clog2(SUM_W);
	localparam int NORM_STEPS = E_W;
	localparam int L_W     = E_W + 16;
	localparam int MUL_W   = L_W + 1;
	localparam int PROD_W  = 2 * MUL_W;

	// 10*log10(2) in Q16
	localparam logic [17:0] DB_PER_LOG2 = 18'd197283;

	// round(65536*log2(1+k/16))
	localparam logic [16:0] LOG_T [0:16] = '{
		17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
		17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
		17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
	};

	// Elaboration-time dB in Q8.8 of a small positive integer
	function automatic logic [15:0] db_of_const(input int unsigned x);
		longint unsigned v;
		longint unsigned f16;
		longint unsigned k;
		longint unsigned r;
		longint unsigned frac;
		longint unsigned l;
		int unsigned e;
		v = x;
		e = 0;
		for (int i = 0; i < 31; i++) begin
			if ((v >> (e + 1)) != 0)
				e = e + 1;
		end
		if (e >= 16)
			f16 = (v >> (e - 16)) & 64'hFFFF;
		else
			f16 = (v << (16 - e)) & 64'hFFFF;
		k = f16 >> 12;
		r = f16 & 64'hFFF;
		frac = LOG_T[5'(k)] + (((LOG_T[5'(k + 1)] - LOG_T[5'(k)]) * r + 2048) >> 12);
		l = (longint'(e) << 16) + frac;
		return 16'((l * DB_PER_LOG2 + (64'd1 << 23)) >> 24);
	endfunction

	// dB of the sample count, subtracted to turn the sum into a mean
	localparam logic [15:0] DB_OF_SPB = db_of_const(SAMPLES_PER_BAND);

	typedef struct packed {
		logic [CFG_W-1:0]    level_offset;
		logic [FACTOR_W-1:0] decay_factor;
		logic [CFG_W-1:0]    snap_threshold;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

/* rtl/bpdb_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bpdb_in_if import bpdb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic                       channel;
	logic [BAND_W-1:0]          band;
	logic signed [SAMPLE_W-1:0] sample_0;
	logic signed [SAMPLE_W-1:0] sample_1;
	logic signed [SAMPLE_W-1:0] sample_2;
	logic signed [SAMPLE_W-1:0] sample_3;
	logic signed [SAMPLE_W-1:0] sample_4;
	logic signed [SAMPLE_W-1:0] sample_5;
	logic signed [SAMPLE_W-1:0] sample_6;
	logic signed [SAMPLE_W-1:0] sample_7;
	logic signed [SAMPLE_W-1:0] sample_8;

	modport source (
		output valid, opcode, channel, band,
		output sample_0, sample_1, sample_2, sample_3, sample_4,
		output sample_5, sample_6, sample_7, sample_8,
		input  ready
	);

	modport sink (
		input  valid, opcode, channel, band,
		input  sample_0, sample_1, sample_2, sample_3, sample_4,
		input  sample_5, sample_6, sample_7, sample_8,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/bpdb_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bpdb_out_if import bpdb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BAND_W-1:0]  out_band;
	logic               out_channel;
	logic [LEVEL_W-1:0] level_db;
	logic               last;

	modport source (
		output valid, out_band, out_channel, level_db, last,
		input  ready
	);

	modport sink (
		input  valid, out_band, out_channel, level_db, last,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/bpdb_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier with a registered product; hold when not enabled.
module bpdb_mul import bpdb_pkg::*; (
	input  wire logic                     clk,
	input  wire mul_req_t                 req,
	output logic signed [PROD_W-1:0]      prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= req.a * req.b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* rtl/bpdb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpdb_ctrl import bpdb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	bpdb_in_if.sink                     item,
	bpdb_out_if.source                  result,
	input  wire cfg_t                   cfg,
	output mul_req_t                    mul_req,
	input  wire logic signed [PROD_W-1:0] mul_prod
);

	localparam int CNT_W = (SAMPLES_PER_BAND > 1) ? $clog2(SAMPLES_PER_BAND) : 1;
	localparam int STP_W = (NORM_STEPS > 1) ? $clog2(NORM_STEPS) : 1;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SQ        = 4'd1;
	localparam logic [3:0] ST_SQ_END    = 4'd2;
	localparam logic [3:0] ST_NORM_INIT = 4'd3;
	localparam logic [3:0] ST_NORM      = 4'd4;
	localparam logic [3:0] ST_INTERP    = 4'd5;
	localparam logic [3:0] ST_LOG_SUM   = 4'd6;
	localparam logic [3:0] ST_DB_MUL    = 4'd7;
	localparam logic [3:0] ST_DB_END    = 4'd8;
	localparam logic [3:0] ST_EMIT_UPD  = 4'd9;
	localparam logic [3:0] ST_DK_RD     = 4'd10;
	localparam logic [3:0] ST_DK_MUL    = 4'd11;
	localparam logic [3:0] ST_DK_EMIT   = 4'd12;

	logic [3:0] state_q, state_d;

	logic                       accept;
	logic signed [SAMPLE_W-1:0] smp_in [9];
	logic signed [SAMPLE_W-1:0] smp_q  [SAMPLES_PER_BAND];
	logic [CNT_W-1:0]           cnt_q;
	logic [STP_W-1:0]           stp_q;
	logic                       acc_en_q;
	logic [SUM_W-1:0]           acc_q;
	logic [E_W-1:0]             e_q;
	logic [L_W-1:0]             l_q;
	logic [LEVEL_W-1:0]         level_q;
	logic [BAND_W-1:0]          band_q;
	logic                       ch_q;
	logic                       in_range;
	logic                       walk_end;

	// Normalize
	logic [E_W-1:0] sh;
	logic           top_zero;

	// Log interpolation
	logic [3:0]         k_idx;
	logic [11:0]        r_frac;
	logic [16:0]        t_lo;
	logic [16:0]        t_hi;
	logic [12:0]        t_diff;
	logic [PROD_W-1:0]  prod_u;
	logic [PROD_W-1:0]  interp_rnd;
	logic [16:0]        frac;
	logic [PROD_W-1:0]  db_rnd;
	logic [LEVEL_W-1:0] db_val;
	logic signed [LEVEL_W+1:0] lvl_sum;
	logic [LEVEL_W-1:0] lvl_clamped;

	// Decay
	logic [LEVEL_W-1:0] decayed;
	logic [LEVEL_W-1:0] decay_snapped;

	// Level table
	logic [LEVEL_W-1:0]     lvl_mem [LEVEL_COUNT];
	logic [LEVEL_COUNT-1:0] lvl_vld_q;
	logic [LEVEL_W-1:0]     rd_data_q;
	logic                   rd_vld_q;
	logic [IDX_W-1:0]       idx;
	logic [LEVEL_W-1:0]     rd_level;
	logic                   wr_en;
	logic [LEVEL_W-1:0]     wr_data;

	// Output register
	logic               out_vld_q;
	logic [BAND_W-1:0]  out_band_q;
	logic               out_ch_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_last_q;
	logic               slot_free;
	logic               emit;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	assign smp_in[0] = item.sample_0;
	assign smp_in[1] = item.sample_1;
	assign smp_in[2] = item.sample_2;
	assign smp_in[3] = item.sample_3;
	assign smp_in[4] = item.sample_4;
	assign smp_in[5] = item.sample_5;
	assign smp_in[6] = item.sample_6;
	assign smp_in[7] = item.sample_7;
	assign smp_in[8] = item.sample_8;

	assign in_range = (int'(item.band) < NUM_BANDS) && (int'(item.channel) < NUM_CHANNELS);
	assign walk_end = (band_q == BAND_W'(NUM_BANDS - 1)) && (ch_q == 1'(NUM_CHANNELS - 1));
	assign idx      = IDX_W'(int'(band_q) * NUM_CHANNELS + int'(ch_q));

	assign sh       = E_W'(1) << (STP_W'(NORM_STEPS - 1) - stp_q);
	assign top_zero = ((acc_q >> (SUM_W - int'(sh))) == '0);

	// Bits just below the leading one once normalized
	assign k_idx  = acc_q[SUM_W-2 -: 4];
	assign r_frac = acc_q[SUM_W-6 -: 12];
	assign t_lo   = LOG_T[5'(k_idx)];
	assign t_hi   = LOG_T[5'(k_idx) + 5'd1];
	assign t_diff = 13'(t_hi - t_lo);

	assign prod_u     = mul_prod;
	assign interp_rnd = prod_u + PROD_W'(2048);
	assign frac       = t_lo + 17'(interp_rnd[12 +: 13]);
	assign db_rnd     = prod_u + (PROD_W'(1) << 23);
	assign db_val     = db_rnd[24 +: LEVEL_W];
	assign lvl_sum    = signed'({2'b00, cfg.level_offset}) + signed'({2'b00, db_val})
			- signed'({2'b00, DB_OF_SPB});

	always_comb begin
		if (lvl_sum < 0)
			lvl_clamped = '0;
		else if (lvl_sum > signed'({2'b00, {LEVEL_W{1'b1}}}))
			lvl_clamped = {LEVEL_W{1'b1}};
		else
			lvl_clamped = lvl_sum[LEVEL_W-1:0];
	end

	assign rd_level      = rd_vld_q ? rd_data_q : '0;
	assign decayed       = prod_u[8 +: LEVEL_W];
	assign decay_snapped = (decayed < cfg.snap_threshold) ? '0 : decayed;

	assign slot_free = !out_vld_q || result.ready;
	assign emit      = slot_free && ((state_q == ST_EMIT_UPD) || (state_q == ST_DK_EMIT));
	assign wr_en     = emit;
	assign wr_data   = (state_q == ST_DK_EMIT) ? decay_snapped : level_q;

	// Drive the shared multiplier
	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_SQ: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'(smp_q[cnt_q]);
				mul_req.b  = MUL_W'(smp_q[cnt_q]);
			end
			ST_INTERP: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'({1'b0, t_diff});
				mul_req.b  = MUL_W'({1'b0, r_frac});
			end
			ST_DB_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'({1'b0, l_q});
				mul_req.b  = MUL_W'({1'b0, DB_PER_LOG2});
			end
			ST_DK_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'({1'b0, rd_level});
				mul_req.b  = MUL_W'({1'b0, cfg.decay_factor});
			end
			default: mul_req = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.opcode == OP_DECAY)
						state_d = ST_DK_RD;
					else if (in_range)
						state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (cnt_q == CNT_W'(SAMPLES_PER_BAND - 1))
					state_d = ST_SQ_END;
			end
			ST_SQ_END:    state_d = ST_NORM_INIT;
			ST_NORM_INIT: state_d = (acc_q == '0) ? ST_EMIT_UPD : ST_NORM;
			ST_NORM: begin
				if (stp_q == STP_W'(NORM_STEPS - 1))
					state_d = ST_INTERP;
			end
			ST_INTERP:  state_d = ST_LOG_SUM;
			ST_LOG_SUM: state_d = ST_DB_MUL;
			ST_DB_MUL:  state_d = ST_DB_END;
			ST_DB_END:  state_d = ST_EMIT_UPD;
			ST_EMIT_UPD: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			ST_DK_RD:  state_d = ST_DK_MUL;
			ST_DK_MUL: state_d = ST_DK_EMIT;
			ST_DK_EMIT: begin
				if (slot_free)
					state_d = walk_end ? ST_IDLE : ST_DK_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			stp_q    <= '0;
			acc_en_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			acc_en_q <= (state_q == ST_SQ);
			if (accept)
				cnt_q <= '0;
			else if (state_q == ST_SQ)
				cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_NORM_INIT)
				stp_q <= '0;
			else if (state_q == ST_NORM)
				stp_q <= stp_q + STP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < SAMPLES_PER_BAND; i++)
				smp_q[i] <= smp_in[i];
			acc_q <= '0;
			if (item.opcode == OP_DECAY) begin
				band_q <= '0;
				ch_q   <= 1'b0;
			end else begin
				band_q <= item.band;
				ch_q   <= item.channel;
			end
		end else begin
			if (acc_en_q)
				acc_q <= acc_q + SUM_W'(mul_prod[SQ_W-1:0]);
			case (state_q)
				ST_NORM_INIT: begin
					e_q     <= E_W'(SUM_W - 1);
					level_q <= '0;
				end
				ST_NORM: begin
					if (top_zero) begin
						acc_q <= acc_q << sh;
						e_q   <= e_q - sh;
					end
				end
				ST_LOG_SUM: l_q <= {e_q, 16'd0} + L_W'(frac);
				ST_DB_END:  level_q <= lvl_clamped;
				ST_DK_EMIT: begin
					// Advance the walk, channel inner
					if (slot_free && !walk_end) begin
						if (ch_q == 1'(NUM_CHANNELS - 1)) begin
							ch_q   <= 1'b0;
							band_q <= band_q + BAND_W'(1);
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Level table storage
	always_ff @(posedge clk) begin
		if (wr_en)
			lvl_mem[idx] <= wr_data;
		rd_data_q <= lvl_mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en)
				lvl_vld_q[idx] <= 1'b1;
			rd_vld_q <= lvl_vld_q[idx];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (emit)
			out_vld_q <= 1'b1;
		else if (result.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_band_q  <= band_q;
			out_ch_q    <= ch_q;
			out_level_q <= wr_data;
			out_last_q  <= (state_q == ST_EMIT_UPD) || walk_end;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.out_band    = out_band_q;
	assign result.out_channel = out_ch_q;
	assign result.level_db    = out_level_q;
	assign result.last        = out_last_q;

endmodule

`default_nettype wire

/* rtl/band_power_db_meter_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Payload
// item      in   valid / ready    opcode, channel, band, sample_0..sample_8
// result    out  valid / ready    out_band, out_channel, level_db, last
// cfg       in   cfg_we           cfg_index, cfg_data (no read-back)
//
// A band update squares each of the nine samples on the shared multiplier,
// runs six steps of leading-one search, then makes two more multiplier
// passes for the log interpolation and the dB scale before the result.
// Zero power skips the search and the log and goes straight to the result.
// A decay walks all 64 table entries, each through read, multiply, then
// write and emit; the walk waits whenever the result side stalls.
// Reset clears control, config and table valid bits at once; no sweep.
// A stalled result beat blocks the next write-back; item.ready stays high
// while a final beat waits, so the next item starts behind it.

module band_power_db_meter_core import bpdb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bpdb_in_if.sink                   item,
	bpdb_out_if.source                result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_t                     cfg_q;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] mul_prod;

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_offset   <= LEVEL_OFFSET_RST;
			cfg_q.decay_factor   <= DECAY_FACTOR_RST;
			cfg_q.snap_threshold <= SNAP_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_OFFSET:   cfg_q.level_offset   <= cfg_data;
				REG_DECAY_FACTOR:   cfg_q.decay_factor   <= cfg_data[FACTOR_W-1:0];
				REG_SNAP_THRESHOLD: cfg_q.snap_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, level table and result register
	bpdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.cfg      (cfg_q),
		.mul_req  (mul_req),
		.mul_prod (mul_prod)
	);

	// One multiplier serves squares, log interpolation, dB scale and decay
	bpdb_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

endmodule

`default_nettype wire

/* rtl/bpdb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpdb_checker import bpdb_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_ready,
	input wire logic               item_opcode,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic               res_last,
	input wire logic [BAND_W-1:0]  res_band,
	input wire logic               res_channel,
	input wire logic [LEVEL_W-1:0] res_level
);

	// A stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_level)
			&& $stable(res_band) && $stable(res_channel) && $stable(res_last))
		else $error("result beat changed while stalled");

	// A pending beat that is not the last one belongs to a decay walk in flight
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !item_ready)
		else $error("item accepted during a decay walk");

	// A decay beat always starts a walk
	a_decay_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_opcode == OP_DECAY) |=> !item_ready)
		else $error("decay did not start a walk");

endmodule

bind band_power_db_meter_core bpdb_checker u_bpdb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_opcode (item.opcode),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_last    (result.last),
	.res_band    (result.out_band),
	.res_channel (result.out_channel),
	.res_level   (result.level_db)
);

`default_nettype wire

/* tb/sv/band_power_db_meter_core_tb.sv */
`timescale 1ns / 1ps

module band_power_db_meter_core_tb;
	import bpdb_pkg::*;

	typedef longint unsigned u64_t;

	// Index 3 of the register port is not mapped to any register
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	// Sender gaps and receiver stalls, in cycles
	localparam int MAX_GAP   = 30;
	localparam int MAX_STALL = 12;

	// Random part: items spread over four register settings
	localparam int RAND_ITEMS = 320;
	localparam int RAND_PHASES = 4;

	// Wait this long after the last owed beat before calling the run done,
	// so any stray beat still has time to show
	localparam int DRAIN_TAIL = 200;

	// Worst item: a full sweep, every beat held by the longest stall,
	// behind the longest sender gap. Budget that for every item, then x4.
	localparam int ITEM_WORST  = LEVEL_COUNT * (4 + MAX_STALL) + MAX_GAP + 32;
	localparam int CYCLE_LIMIT = 4 * (RAND_ITEMS + 40) * ITEM_WORST;

	// round(65536*log2(1+k/16)), k = 0..16
	localparam u64_t LOG2_FRAC [0:16] = '{
		64'd0,     64'd5732,  64'd11136, 64'd16248, 64'd21098, 64'd25711,
		64'd30109, 64'd34312, 64'd38336, 64'd42196, 64'd45904, 64'd49472,
		64'd52911, 64'd56229, 64'd59434, 64'd62534, 64'd65536
	};
	// 10*log10(2) in Q16
	localparam u64_t DB_PER_OCTAVE = 64'd197283;

	typedef struct packed {
		logic                                   opcode;
		logic                                   channel;
		logic [BAND_W-1:0]                      band;
		logic [SAMPLES_PER_BAND-1:0][SAMPLE_W-1:0] smp;
	} band_item_t;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic               channel;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} level_beat_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bpdb_in_if  item_bus ();
	bpdb_out_if level_bus ();

	band_power_db_meter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_bus),
		.result    (level_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the level table and of the three registers
	logic [LEVEL_W-1:0]  level_table [LEVEL_COUNT];
	logic [CFG_W-1:0]    cur_offset;
	logic [FACTOR_W-1:0] cur_factor;
	logic [CFG_W-1:0]    cur_snap;

	// Levels the block still owes us, oldest first
	level_beat_t pending_levels [$];

	int burst_left  = 0;
	int n_updates   = 0;
	int n_decays    = 0;
	int n_beats     = 0;
	int n_cfg       = 0;
	int n_errors    = 0;
	int cycle_count = 0;

	rx_mode_t    rx_mode  = RX_OPEN;
	int unsigned rx_hold  = 0;
	int unsigned rx_stall = 0;

	// dB in Q8.8 of a positive power: log2 from the top set bit plus a
	// 17-entry interpolated fraction table, then scaled to decibels
	function automatic u64_t db_q88(input u64_t x);
		int   msb;
		u64_t f16;
		u64_t k;
		u64_t r;
		u64_t frac;
		u64_t lg;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (x[i])
				msb = i;
		if (msb >= 16)
			f16 = (x >> (msb - 16)) & 64'hFFFF;
		else
			f16 = (x << (16 - msb)) & 64'hFFFF;
		k = f16 >> 12;
		r = f16 & 64'hFFF;
		frac = LOG2_FRAC[k] + (((LOG2_FRAC[k + 1] - LOG2_FRAC[k]) * r + 64'd2048) >> 12);
		lg = (64'(msb) << 16) + frac;
		return (lg * DB_PER_OCTAVE + (64'd1 << 23)) >> 24;
	endfunction

	// Work out the beats one accepted item causes and advance the table
	task automatic predict_levels(input band_item_t it);
		u64_t              power;
		longint            s;
		longint            lvl;
		int unsigned       scaled;
		logic [IDX_W-1:0]  slot;
		level_beat_t       beat;
		if (it.opcode == OP_UPDATE) begin
			power = 0;
			for (int i = 0; i < SAMPLES_PER_BAND; i++) begin
				s = longint'($signed(it.smp[i]));
				power += s * s;
			end
			// Zero power reads as level 0 whatever the offset
			lvl = 0;
			if (power != 0) begin
				lvl = longint'(cur_offset) + longint'(db_q88(power))
					- longint'(db_q88(SAMPLES_PER_BAND));
				if (lvl < 0)
					lvl = 0;
				if (lvl > 65535)
					lvl = 65535;
			end
			slot = {it.band, it.channel};
			level_table[slot] = LEVEL_W'(lvl);
			beat.band    = it.band;
			beat.channel = it.channel;
			beat.level   = LEVEL_W'(lvl);
			beat.last    = 1'b1;
			pending_levels.push_back(beat);
			n_updates++;
		end else begin
			// Sweep band by band, channel inner; snap small levels to zero
			for (int b = 0; b < NUM_BANDS; b++) begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					slot = IDX_W'(b * NUM_CHANNELS + c);
					scaled = (32'(level_table[slot]) * 32'(cur_factor)) >> 8;
					if (scaled < 32'(cur_snap))
						scaled = 0;
					level_table[slot] = LEVEL_W'(scaled);
					beat.band    = BAND_W'(b);
					beat.channel = 1'(c);
					beat.level   = LEVEL_W'(scaled);
					beat.last    = (b == NUM_BANDS - 1) && (c == NUM_CHANNELS - 1);
					pending_levels.push_back(beat);
				end
			end
			n_decays++;
		end
	endtask

	// Compare one accepted result beat with the oldest owed level
	task automatic check_level_beat();
		level_beat_t want;
		if (pending_levels.size() == 0) begin
			$error("result beat with nothing owed: band %0d channel %0d level %0d",
				level_bus.out_band, level_bus.out_channel, level_bus.level_db);
			n_errors++;
		end else begin
			want = pending_levels.pop_front();
			n_beats++;
			if (level_bus.out_band !== want.band) begin
				$error("out_band mismatch: expected %0d, actual %0d",
					want.band, level_bus.out_band);
				n_errors++;
			end
			if (level_bus.out_channel !== want.channel) begin
				$error("out_channel mismatch: expected %0d, actual %0d",
					want.channel, level_bus.out_channel);
				n_errors++;
			end
			if (level_bus.level_db !== want.level) begin
				$error("level_db mismatch: expected %0d, actual %0d",
					want.level, level_bus.level_db);
				n_errors++;
			end
			if (level_bus.last !== want.last) begin
				$error("last mismatch: expected %0d, actual %0d",
					want.last, level_bus.last);
				n_errors++;
			end
		end
	endtask

	// Result side: check on every accepted beat; ready follows a mode that
	// is redrawn after a random hold (always open, coin toss, mostly
	// closed, or open with stall stretches)
	initial begin : level_sink
		level_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (level_bus.valid === 1'b1 && level_bus.ready === 1'b1)
				check_level_beat();
			if (rx_hold == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_hold <= $urandom_range(16, 160);
			end else begin
				rx_hold <= rx_hold - 1;
			end
			if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				level_bus.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: level_bus.ready <= 1'b1;
					RX_COIN: level_bus.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: level_bus.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						level_bus.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							rx_stall <= $urandom_range(1, MAX_STALL);
					end
				endcase
			end
		end
	end

	// Watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one item and hold it until accepted. Items go out in bursts;
	// at the start of each burst drop valid for a random gap.
	task automatic send_item(input band_item_t it);
		if (burst_left == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		item_bus.valid    <= 1'b1;
		item_bus.opcode   <= it.opcode;
		item_bus.channel  <= it.channel;
		item_bus.band     <= it.band;
		item_bus.sample_0 <= it.smp[0];
		item_bus.sample_1 <= it.smp[1];
		item_bus.sample_2 <= it.smp[2];
		item_bus.sample_3 <= it.smp[3];
		item_bus.sample_4 <= it.smp[4];
		item_bus.sample_5 <= it.smp[5];
		item_bus.sample_6 <= it.smp[6];
		item_bus.sample_7 <= it.smp[7];
		item_bus.sample_8 <= it.smp[8];
		@(posedge clk);
		while (item_bus.ready !== 1'b1)
			@(posedge clk);
		predict_levels(it);
	endtask

	// Hold the sender until every owed level has come back
	task automatic drain_results();
		item_bus.valid <= 1'b0;
		burst_left = 0;
		while (pending_levels.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LEVEL_OFFSET:   cur_offset = data;
			REG_DECAY_FACTOR:   cur_factor = data[FACTOR_W-1:0];
			REG_SNAP_THRESHOLD: cur_snap   = data;
			default: ;
		endcase
		n_cfg++;
	endtask

	function automatic band_item_t flat_update(input logic ch, input int band,
		input logic [SAMPLE_W-1:0] value);
		band_item_t it;
		it.opcode  = OP_UPDATE;
		it.channel = ch;
		it.band    = BAND_W'(band);
		for (int i = 0; i < SAMPLES_PER_BAND; i++)
			it.smp[i] = value;
		return it;
	endfunction

	// Band and samples are don't-care on a decay; randomize them anyway
	function automatic band_item_t make_decay();
		band_item_t it;
		it.opcode  = OP_DECAY;
		it.channel = 1'($urandom_range(0, 1));
		it.band    = BAND_W'($urandom_range(0, NUM_BANDS - 1));
		for (int i = 0; i < SAMPLES_PER_BAND; i++)
			it.smp[i] = SAMPLE_W'($urandom);
		return it;
	endfunction

	// Mix of full-scale noise, signed small magnitudes, a lone sample and
	// silence so levels land across the whole dB range
	function automatic band_item_t rand_update();
		band_item_t  it;
		int          mag;
		int unsigned shape;
		it.opcode  = OP_UPDATE;
		it.channel = 1'($urandom_range(0, 1));
		it.band    = BAND_W'($urandom_range(0, NUM_BANDS - 1));
		shape = $urandom_range(0, 19);
		for (int i = 0; i < SAMPLES_PER_BAND; i++) begin
			mag = $urandom_range(0, 32767) >> $urandom_range(0, 15);
			if (shape < 9)
				it.smp[i] = SAMPLE_W'($urandom);
			else if (shape < 17)
				it.smp[i] = ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
			else if (shape < 19)
				it.smp[i] = (i == 0) ? SAMPLE_W'(mag) : '0;
			else
				it.smp[i] = '0;
		end
		return it;
	endfunction

	// The table must read all zero straight out of reset
	task automatic test_cleared_table();
		send_item(make_decay());
	endtask

	// Silence, full scale both signs, the smallest powers, bit patterns,
	// the first band on channel 0 and the last band on channel 1
	task automatic test_update_extremes();
		band_item_t it;
		send_item(flat_update(1'b0, 0, 16'h0000));
		send_item(flat_update(1'b1, NUM_BANDS - 1, 16'h8000));
		send_item(flat_update(1'b0, 15, 16'h7FFF));
		it = flat_update(1'b1, 1, 16'h0000);
		it.smp[0] = 16'h0001;
		send_item(it);
		it = flat_update(1'b0, 2, 16'h0000);
		it.smp[SAMPLES_PER_BAND - 1] = 16'hFFFF;
		send_item(it);
		it = flat_update(1'b1, 21, 16'h5555);
		for (int i = 1; i < SAMPLES_PER_BAND; i += 2)
			it.smp[i] = 16'hAAAA;
		send_item(it);
	endtask

	// Clamp at zero with no offset, saturate with the largest offset
	task automatic test_offset_clamp();
		band_item_t it;
		write_reg(REG_LEVEL_OFFSET, 16'h0000);
		it = flat_update(1'b0, 4, 16'h0000);
		it.smp[3] = 16'h0001;
		send_item(it);
		send_item(flat_update(1'b1, 4, 16'h0100));
		write_reg(REG_LEVEL_OFFSET, 16'hFFFF);
		send_item(flat_update(1'b0, 9, 16'h8000));
		// Zero power still reads 0 under the largest offset
		send_item(flat_update(1'b1, 9, 16'h0000));
		write_reg(REG_LEVEL_OFFSET, LEVEL_OFFSET_RST);
	endtask

	// Decay at the default, with the largest factor and no snap, with full snap and with factor 0
	task automatic test_decay_extremes();
		send_item(flat_update(1'b0, 3, 16'h7FFF));
		send_item(flat_update(1'b1, 20, 16'h0064));
		send_item(make_decay());
		write_reg(REG_DECAY_FACTOR, {8'hA5, 8'hFF});
		write_reg(REG_SNAP_THRESHOLD, 16'h0000);
		send_item(make_decay());
		write_reg(REG_SNAP_THRESHOLD, 16'hFFFF);
		send_item(make_decay());
		send_item(flat_update(1'b1, 7, 16'd20000));
		write_reg(REG_DECAY_FACTOR, {8'h5A, 8'h00});
		write_reg(REG_SNAP_THRESHOLD, 16'h0000);
		send_item(make_decay());
		write_reg(REG_DECAY_FACTOR, {8'h00, DECAY_FACTOR_RST});
		write_reg(REG_SNAP_THRESHOLD, SNAP_THRESHOLD_RST);
	endtask

	// A write to the unmapped index must leave every register alone
	task automatic test_unmapped_register();
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_item(flat_update(1'b0, 30, 16'h1234));
	endtask

	// Random traffic over several register settings, extremes among them;
	// once mid-run let the sender sit until every owed level is back
	task automatic test_random_traffic();
		band_item_t        it;
		logic [CFG_W-1:0]  off;
		logic [CFG_W-1:0]  snap;
		logic [FACTOR_W-1:0] fac;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: off = '0;
				1: off = '1;
				default: off = CFG_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: fac = '0;
				1: fac = '1;
				default: fac = FACTOR_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: snap = '0;
				1: snap = '1;
				2: snap = CFG_W'($urandom);
				default: snap = CFG_W'($urandom_range(0, 4000));
			endcase
			write_reg(REG_LEVEL_OFFSET, off);
			write_reg(REG_DECAY_FACTOR, {8'($urandom), fac});
			write_reg(REG_SNAP_THRESHOLD, snap);
			for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
				if (phase == 2 && n == RAND_ITEMS / (2 * RAND_PHASES))
					drain_results();
				if ($urandom_range(0, 9) == 0)
					it = make_decay();
				else
					it = rand_update();
				send_item(it);
			end
		end
	endtask

	initial begin : stimulus
		arst_n            <= 1'b0;
		item_bus.valid    <= 1'b0;
		item_bus.opcode   <= OP_UPDATE;
		item_bus.channel  <= 1'b0;
		item_bus.band     <= '0;
		item_bus.sample_0 <= '0;
		item_bus.sample_1 <= '0;
		item_bus.sample_2 <= '0;
		item_bus.sample_3 <= '0;
		item_bus.sample_4 <= '0;
		item_bus.sample_5 <= '0;
		item_bus.sample_6 <= '0;
		item_bus.sample_7 <= '0;
		item_bus.sample_8 <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_LEVEL_OFFSET;
		cfg_data          <= '0;
		for (int i = 0; i < LEVEL_COUNT; i++)
			level_table[i] = '0;
		cur_offset = LEVEL_OFFSET_RST;
		cur_factor = DECAY_FACTOR_RST;
		cur_snap   = SNAP_THRESHOLD_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_table();
		test_update_extremes();
		test_offset_clamp();
		test_decay_extremes();
		test_unmapped_register();
		test_random_traffic();

		// Let the last sweep finish, then give the block time to show any
		// stray beat
		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (pending_levels.size() != 0) begin
			$error("%0d level beats never arrived", pending_levels.size());
			n_errors++;
		end

		$display("Run covered %0d band updates and %0d decay sweeps across %0d register writes.",
			n_updates, n_decays, n_cfg);
		$display("%0d level beats compared with the predicted table, %0d errors.",
			n_beats, n_errors);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
